// ===== rtl/core/fp8m_pkg.sv =====
package fp8m_pkg;

    localparam int unsigned OperandWidth = 8;
    localparam int unsigned ExpWidth     = 5;
    localparam int unsigned MantWidth    = 2;
    localparam int unsigned SigWidth     = MantWidth + 1;
    localparam int unsigned ProdWidth    = 2 * SigWidth;
    // wide enough for e_a + e_b + 1 - bias + carry, signed
    localparam int unsigned ExpSumWidth  = ExpWidth + 3;

    localparam logic [OperandWidth-1:0] NanCode  = 8'h80;
    localparam logic [OperandWidth-1:0] ZeroCode = 8'h00;
    localparam logic [OperandWidth-2:0] SatMag   = 7'h7F;
    localparam logic [ExpSumWidth-1:0]  ExpBias  = 8'd15;
    localparam logic [ExpSumWidth-1:0]  ExpMax   = 8'd31;

    // APB register map
    localparam int unsigned ApbAddrWidth = 2;
    localparam int unsigned ApbDataWidth = 32;
    localparam logic [ApbAddrWidth-1:0] RegTruncateMode = 2'd0;

    localparam logic TruncateModeReset = 1'b0;

    // operands as held in the input stage
    typedef struct packed {
        logic [OperandWidth-1:0] a;
        logic [OperandWidth-1:0] b;
    } t_operands;

endpackage

// ===== rtl/core/fp8m_apb_regs.sv =====
module fp8m_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fp8m_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [fp8m_pkg::ApbDataWidth-1:0]  pwdata,
    output logic [fp8m_pkg::ApbDataWidth-1:0]  prdata,
    output logic                               pready,
    output logic                               o_truncate_mode
);

    logic r_truncate_mode;
    logic n_truncate_mode;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr == fp8m_pkg::RegTruncateMode);

    always_comb begin
        n_truncate_mode = r_truncate_mode;
        if (w_wr) begin
            n_truncate_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_truncate_mode <= fp8m_pkg::TruncateModeReset;
        end else begin
            r_truncate_mode <= n_truncate_mode;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == fp8m_pkg::RegTruncateMode) begin
            prdata[0] = r_truncate_mode;
        end
    end

    assign o_truncate_mode = r_truncate_mode;

endmodule

// ===== rtl/core/fp8m_mul_core.sv =====
module fp8m_mul_core (
    input  fp8m_pkg::t_operands                    i_ops,
    input  logic                                   i_truncate_mode,
    output logic [fp8m_pkg::OperandWidth-1:0]      o_product
);

    localparam int unsigned EW = fp8m_pkg::ExpWidth;
    localparam int unsigned MW = fp8m_pkg::MantWidth;
    localparam int unsigned SW = fp8m_pkg::SigWidth;
    localparam int unsigned PW = fp8m_pkg::ProdWidth;
    localparam int unsigned XW = fp8m_pkg::ExpSumWidth;

    logic          w_nan, w_zero, w_sign, w_hi;
    logic [SW-1:0] w_sig_a, w_sig_b;
    logic [PW-1:0] w_prod;
    logic [EW-1:0] w_exp_a, w_exp_b;
    logic [XW-1:0] w_exp, w_exp_fin;
    logic [MW-1:0] w_mant;
    logic          w_gt_half, w_eq_half, w_round;
    logic [MW:0]   w_mant_r;

    assign w_nan  = (i_ops.a == fp8m_pkg::NanCode) || (i_ops.b == fp8m_pkg::NanCode);
    assign w_zero = (i_ops.a == fp8m_pkg::ZeroCode) || (i_ops.b == fp8m_pkg::ZeroCode);
    assign w_sign = i_ops.a[7] ^ i_ops.b[7];

    assign w_exp_a = i_ops.a[MW +: EW];
    assign w_exp_b = i_ops.b[MW +: EW];
    assign w_sig_a = {1'b1, i_ops.a[MW-1:0]};
    assign w_sig_b = {1'b1, i_ops.b[MW-1:0]};
    assign w_prod  = PW'({{SW{1'b0}}, w_sig_a} * {{SW{1'b0}}, w_sig_b});
    assign w_hi    = w_prod[PW-1];

    // biased exponent, signed two's complement
    assign w_exp = XW'(w_exp_a) + XW'(w_exp_b) + XW'(w_hi) - fp8m_pkg::ExpBias;

    always_comb begin
        if (w_hi) begin
            w_mant    = w_prod[4:3];
            w_gt_half = w_prod[2] && (w_prod[1:0] != 2'b00);
            w_eq_half = (w_prod[2:0] == 3'b100);
        end else begin
            w_mant    = w_prod[3:2];
            w_gt_half = (w_prod[1:0] == 2'b11);
            w_eq_half = (w_prod[1:0] == 2'b10);
        end
    end

    assign w_round   = !i_truncate_mode && (w_gt_half || (w_eq_half && w_mant[0]));
    assign w_mant_r  = {1'b0, w_mant} + (MW+1)'(w_round);
    assign w_exp_fin = w_exp + XW'(w_mant_r[MW]);

    always_comb begin
        if (w_nan) begin
            o_product = fp8m_pkg::NanCode;
        end else if (w_zero || w_exp_fin[XW-1]) begin
            o_product = fp8m_pkg::ZeroCode;
        end else if (w_exp_fin > fp8m_pkg::ExpMax) begin
            o_product = {w_sign, fp8m_pkg::SatMag};
        end else if ((w_exp_fin == '0) && (w_mant_r[MW-1:0] == '0)) begin
            o_product = fp8m_pkg::ZeroCode;
        end else begin
            o_product = {w_sign, w_exp_fin[EW-1:0], w_mant_r[MW-1:0]};
        end
    end

endmodule

// ===== rtl/core/fp8_e5m2_multiplier_unit.sv =====
// E5M2 (1/5/2, bias 15) multiplier. Takes one request per cycle while o_stall
// is low and returns one product per request: operands land in an input
// register, the product is formed by a short combinational path and
// captured in the result register. Code 0x80 is NaN and propagates; 0x00 is
// zero; every other code, exponent 0 included, carries an implicit leading
// one. Underflow flushes to 0x00, overflow saturates to sign|0x7F.
// truncate_mode (APB byte address 0, bit 0) selects truncation (1) or
// round-to-nearest-even (0); write it only while the unit is empty.
// o_stall rises only when both stages hold requests and the sink stalls.
module fp8_e5m2_multiplier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fp8m_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [fp8m_pkg::ApbDataWidth-1:0]  pwdata,
    output logic [fp8m_pkg::ApbDataWidth-1:0]  prdata,
    output logic                               pready,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [fp8m_pkg::OperandWidth-1:0]  i_operand_a,
    input  logic [fp8m_pkg::OperandWidth-1:0]  i_operand_b,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [fp8m_pkg::OperandWidth-1:0]  o_product
);

    logic                                  w_truncate_mode;
    logic                                  w_out_free;
    logic                                  w_s1_move;
    logic                                  w_in_take;
    logic [fp8m_pkg::OperandWidth-1:0]     w_product;

    // input stage
    logic                                  r_s1_valid, n_s1_valid;
    fp8m_pkg::t_operands                   r_s1_ops, n_s1_ops;
    // result stage
    logic                                  r_out_valid, n_out_valid;
    logic [fp8m_pkg::OperandWidth-1:0]     r_product, n_product;

    fp8m_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_truncate_mode (w_truncate_mode)
    );

    fp8m_mul_core u_core (
        .i_ops           (r_s1_ops),
        .i_truncate_mode (w_truncate_mode),
        .o_product       (w_product)
    );

    // result register frees up when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_in_take  = i_valid && !o_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_ops   = r_s1_ops;
        if (!r_s1_valid || w_out_free) begin
            n_s1_valid = i_valid;
        end
        if (w_in_take) begin
            n_s1_ops.a = i_operand_a;
            n_s1_ops.b = i_operand_b;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_product   = r_product;
        if (w_out_free) begin
            n_out_valid = r_s1_valid;
        end
        if (w_s1_move) begin
            n_product = w_product;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ops  <= n_s1_ops;
        r_product <= n_product;
    end

    assign o_valid   = r_out_valid;
    assign o_product = r_product;

endmodule
